### hdl/lwf_pkg.sv
// Package for the LCD window fill byte stream.
// Screen size, panel command codes, sequencer phase and item/result types.
// No dependencies.
package lwf_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;
  localparam int unsigned COORD_W       = 16;

  localparam logic [COORD_W:0] SCREEN_W_EXT = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [COORD_W:0] SCREEN_H_EXT = (COORD_W+1)'(SCREEN_HEIGHT);

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  typedef enum logic {
    KIND_DRAW    = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STYLE_SOLID  = 2'd0,
    STYLE_DASHED = 2'd1,
    STYLE_DOTTED = 2'd2,
    STYLE_BACK   = 2'd3
  } style_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CASET  = 4'd1,
    PH_XS_HI  = 4'd2,
    PH_XS_LO  = 4'd3,
    PH_XE_HI  = 4'd4,
    PH_XE_LO  = 4'd5,
    PH_RASET  = 4'd6,
    PH_YS_HI  = 4'd7,
    PH_YS_LO  = 4'd8,
    PH_YE_HI  = 4'd9,
    PH_YE_LO  = 4'd10,
    PH_RAMWR  = 4'd11,
    PH_PIXELS = 4'd12
  } phase_e;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] extent_x;
    logic [COORD_W-1:0] extent_y;
    logic [1:0]         style;
    logic               pattern_axis;
    logic [15:0]        color;
    logic [15:0]        background;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_data;
    logic       cs_release;
    logic       last;
  } result_t;

endpackage

### hdl/lwf_stream_if.sv
// Valid/ready stream interfaces for draw/advance items and panel bytes.
// Depends on nothing; field widths follow the panel byte stream format.
interface lwf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [15:0] extent_x;
  logic [15:0] extent_y;
  logic [1:0]  style;
  logic        pattern_axis;
  logic [15:0] color;
  logic [15:0] background;

  modport source (output valid, kind, origin_x, origin_y, extent_x, extent_y, style,
                  pattern_axis, color, background, input ready);
  modport sink   (input valid, kind, origin_x, origin_y, extent_x, extent_y, style,
                  pattern_axis, color, background, output ready);
endinterface

interface lwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       is_data;
  logic       cs_release;
  logic       last;

  modport source (output valid, byte_out, is_data, cs_release, last, input ready);
  modport sink   (input valid, byte_out, is_data, cs_release, last, output ready);
endinterface

### hdl/lwf_in_stage.sv
// Input register of the window fill stream: holds one accepted transaction.
// Depends on lwf_pkg and lwf_in_if.
module lwf_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  lwf_in_if.sink          in_i,
  input  logic            take_i,
  output logic            item_valid_o,
  output lwf_pkg::item_t  item_o
);

  logic           valid_q, valid_d;
  lwf_pkg::item_t item_q;
  logic           accept;

  // Free slot, or the held item leaves in this cycle.
  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{kind:         in_i.kind,
                  origin_x:     in_i.origin_x,
                  origin_y:     in_i.origin_y,
                  extent_x:     in_i.extent_x,
                  extent_y:     in_i.extent_y,
                  style:        in_i.style,
                  pattern_axis: in_i.pattern_axis,
                  color:        in_i.color,
                  background:   in_i.background};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### hdl/lwf_seq.sv
// Window fill sequencer: draw state, phase machine, pixel counters and result register.
// Depends on lwf_pkg and lwf_out_if.
module lwf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  lwf_pkg::item_t item_i,
  output logic           take_o,
  lwf_out_if.source      out_o
);

  lwf_pkg::phase_e phase_q, phase_d;
  logic [15:0] start_col_q, start_col_d, start_row_q, start_row_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  logic [15:0] row_cnt_q, row_cnt_d, col_cnt_q, col_cnt_d;
  logic        low_next_q, low_next_d;
  logic [15:0] fore_q, fore_d, back_q, back_d;
  logic [1:0]  style_q, style_d;
  logic        row_pat_q, row_pat_d;

  logic              out_valid_q, out_valid_d;
  lwf_pkg::result_t  res_q, res_d;

  logic        fire;
  logic        emit;
  logic [16:0] sum_x, sum_y;
  logic [15:0] clip_w, clip_h;
  logic        on_screen;
  logic [15:0] end_col, end_row;
  logic [15:0] pat_idx;
  logic        draw_fg;
  logic [15:0] pix;
  logic [16:0] col_inc, row_inc;
  logic        row_wrap, done;

  assign fire   = item_valid_i && (!out_valid_q || out_o.ready);
  assign take_o = fire;

  // Clip against the screen edge.
  assign sum_x     = {1'b0, item_i.origin_x} + {1'b0, item_i.extent_x};
  assign sum_y     = {1'b0, item_i.origin_y} + {1'b0, item_i.extent_y};
  assign clip_w    = (sum_x > lwf_pkg::SCREEN_W_EXT)
                   ? 16'(lwf_pkg::SCREEN_W_EXT - {1'b0, item_i.origin_x}) : item_i.extent_x;
  assign clip_h    = (sum_y > lwf_pkg::SCREEN_H_EXT)
                   ? 16'(lwf_pkg::SCREEN_H_EXT - {1'b0, item_i.origin_y}) : item_i.extent_y;
  assign on_screen = ({1'b0, item_i.origin_x} < lwf_pkg::SCREEN_W_EXT)
                  && ({1'b0, item_i.origin_y} < lwf_pkg::SCREEN_H_EXT);

  assign end_col = start_col_q + width_q - 16'd1;
  assign end_row = start_row_q + height_q - 16'd1;

  always_comb begin
    pat_idx = row_pat_q ? row_cnt_q : col_cnt_q;
    case (lwf_pkg::style_e'(style_q))
      lwf_pkg::STYLE_SOLID:  draw_fg = 1'b1;
      lwf_pkg::STYLE_DASHED: draw_fg = !pat_idx[3];
      lwf_pkg::STYLE_DOTTED: draw_fg = !pat_idx[0];
      default:               draw_fg = 1'b0;
    endcase
    pix = draw_fg ? fore_q : back_q;
  end

  assign col_inc  = {1'b0, col_cnt_q} + 17'd1;
  assign row_inc  = {1'b0, row_cnt_q} + 17'd1;
  assign row_wrap = col_inc >= {1'b0, width_q};
  assign done     = row_wrap && (row_inc >= {1'b0, height_q});

  always_comb begin
    phase_d     = phase_q;
    start_col_d = start_col_q;
    start_row_d = start_row_q;
    width_d     = width_q;
    height_d    = height_q;
    row_cnt_d   = row_cnt_q;
    col_cnt_d   = col_cnt_q;
    low_next_d  = low_next_q;
    fore_d      = fore_q;
    back_d      = back_q;
    style_d     = style_q;
    row_pat_d   = row_pat_q;
    emit        = 1'b0;
    res_d       = res_q;

    if (fire) begin
      if (item_i.kind == lwf_pkg::KIND_DRAW) begin
        if (phase_q == lwf_pkg::PH_IDLE && on_screen) begin
          start_col_d = item_i.origin_x;
          start_row_d = item_i.origin_y;
          width_d     = clip_w;
          height_d    = clip_h;
          style_d     = item_i.style;
          row_pat_d   = item_i.pattern_axis;
          fore_d      = item_i.color;
          back_d      = item_i.background;
          row_cnt_d   = '0;
          col_cnt_d   = '0;
          low_next_d  = 1'b0;
          phase_d     = lwf_pkg::PH_CASET;
        end
      end else begin
        emit = 1'b1;
        case (phase_q)
          lwf_pkg::PH_CASET: begin
            res_d   = '{lwf_pkg::CMD_COLUMN_SET, 1'b0, 1'b1, 1'b0};
            phase_d = lwf_pkg::PH_XS_HI;
          end
          lwf_pkg::PH_XS_HI: begin
            res_d   = '{start_col_q[15:8], 1'b1, 1'b0, 1'b0};
            phase_d = lwf_pkg::PH_XS_LO;
          end
          lwf_pkg::PH_XS_LO: begin
            res_d   = '{start_col_q[7:0], 1'b1, 1'b1, 1'b0};
            phase_d = lwf_pkg::PH_XE_HI;
          end
          lwf_pkg::PH_XE_HI: begin
            res_d   = '{end_col[15:8], 1'b1, 1'b0, 1'b0};
            phase_d = lwf_pkg::PH_XE_LO;
          end
          lwf_pkg::PH_XE_LO: begin
            res_d   = '{end_col[7:0], 1'b1, 1'b1, 1'b0};
            phase_d = lwf_pkg::PH_RASET;
          end
          lwf_pkg::PH_RASET: begin
            res_d   = '{lwf_pkg::CMD_ROW_SET, 1'b0, 1'b1, 1'b0};
            phase_d = lwf_pkg::PH_YS_HI;
          end
          lwf_pkg::PH_YS_HI: begin
            res_d   = '{start_row_q[15:8], 1'b1, 1'b0, 1'b0};
            phase_d = lwf_pkg::PH_YS_LO;
          end
          lwf_pkg::PH_YS_LO: begin
            res_d   = '{start_row_q[7:0], 1'b1, 1'b1, 1'b0};
            phase_d = lwf_pkg::PH_YE_HI;
          end
          lwf_pkg::PH_YE_HI: begin
            res_d   = '{end_row[15:8], 1'b1, 1'b0, 1'b0};
            phase_d = lwf_pkg::PH_YE_LO;
          end
          lwf_pkg::PH_YE_LO: begin
            res_d   = '{end_row[7:0], 1'b1, 1'b1, 1'b0};
            phase_d = lwf_pkg::PH_RAMWR;
          end
          lwf_pkg::PH_RAMWR: begin
            // Empty rectangle: the memory-write command closes the sequence.
            if (width_q == '0 || height_q == '0) begin
              res_d   = '{lwf_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b1};
              phase_d = lwf_pkg::PH_IDLE;
            end else begin
              res_d      = '{lwf_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0};
              phase_d    = lwf_pkg::PH_PIXELS;
              row_cnt_d  = '0;
              col_cnt_d  = '0;
              low_next_d = 1'b0;
            end
          end
          lwf_pkg::PH_PIXELS: begin
            if (!low_next_q) begin
              res_d      = '{pix[15:8], 1'b1, 1'b0, 1'b0};
              low_next_d = 1'b1;
            end else begin
              res_d      = '{pix[7:0], 1'b1, done, done};
              low_next_d = 1'b0;
              if (row_wrap) begin
                col_cnt_d = '0;
                row_cnt_d = done ? '0 : row_inc[15:0];
              end else begin
                col_cnt_d = col_inc[15:0];
              end
              if (done) begin
                phase_d = lwf_pkg::PH_IDLE;
              end
            end
          end
          default: begin
            // Idle, or a code with no meaning: advance is dropped.
            emit    = 1'b0;
            phase_d = lwf_pkg::PH_IDLE;
          end
        endcase
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lwf_pkg::PH_IDLE;
      start_col_q <= '0;
      start_row_q <= '0;
      width_q     <= '0;
      height_q    <= '0;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
      low_next_q  <= 1'b0;
      fore_q      <= '0;
      back_q      <= '0;
      style_q     <= '0;
      row_pat_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      start_col_q <= start_col_d;
      start_row_q <= start_row_d;
      width_q     <= width_d;
      height_q    <= height_d;
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
      low_next_q  <= low_next_d;
      fore_q      <= fore_d;
      back_q      <= back_d;
      style_q     <= style_d;
      row_pat_q   <= row_pat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_out   = res_q.byte_out;
  assign out_o.is_data    = res_q.is_data;
  assign out_o.cs_release = res_q.cs_release;
  assign out_o.last       = res_q.last;

endmodule

### hdl/lcd_window_fill_stream.sv
// An advance's byte passes the input register, then the result register. Throughput:
// one transaction per cycle; a stalled byte holds the sequencer, and the input stalls
// once its register is full too.
// Draw and ignored transactions occupy one slot and produce no byte.
// Reset (rst_ni low, asynchronous): sequencer idle, all draw state cleared.
// Depends on lwf_pkg, lwf_stream_if, lwf_in_stage and lwf_seq.
module lcd_window_fill_stream (
  input  logic      clk_i,
  input  logic      rst_ni,
  lwf_in_if.sink    in_i,
  lwf_out_if.source out_o
);

  logic           take;
  logic           item_valid;
  lwf_pkg::item_t item;

  lwf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lwf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

### hdl/lwf_checker.sv
// Port-level checks for lcd_window_fill_stream, attached by bind.
// Depends on lwf_pkg and the top level's interface ports.
module lwf_port_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] byte_out_i,
  input logic       is_data_i,
  input logic       cs_release_i,
  input logic       last_i
);

  // A held byte stays put until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i)
      && $stable(is_data_i) && $stable(last_i))
    else $error("stalled output byte changed");

  // Input backpressure only comes from a stalled output byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output stall");

  // Command bytes are one of the three panel commands and release chip select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_data_i |-> cs_release_i
      && (byte_out_i == lwf_pkg::CMD_COLUMN_SET || byte_out_i == lwf_pkg::CMD_ROW_SET
          || byte_out_i == lwf_pkg::CMD_MEMORY_WRITE))
    else $error("bad command byte");

  // The closing byte of a sequence always releases chip select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> cs_release_i)
    else $error("last byte without chip select release");

endmodule

bind lcd_window_fill_stream lwf_port_assert u_lwf_port_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .byte_out_i   (out_o.byte_out),
  .is_data_i    (out_o.is_data),
  .cs_release_i (out_o.cs_release),
  .last_i       (out_o.last)
);

### dv/lwf_checker.sv
// Scoreboard for lcd_window_fill_stream: predicts the panel byte stream from
// accepted draw/advance transactions and compares it with the output channel.
// Depends on lwf_pkg and lwf_stream_if.
module lwf_checker
  import lwf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lwf_in_if           in_mon,
  lwf_out_if          out_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 40;

  // predicted sequencer state
  phase_e      phase_q;
  logic [15:0] col0, row0, width, height;
  logic [15:0] row_idx, col_idx;
  logic [15:0] fg, bg;
  logic        lo_next, by_row;
  style_e      fill_style;

  result_t     bytes_due[$];
  int unsigned n_fail = 0;

  assign fail_count_o = n_fail;

  function automatic result_t panel_byte(input logic [7:0] b, input logic data, rel, lst);
    result_t r;
    r.byte_out   = b;
    r.is_data    = data;
    r.cs_release = rel;
    r.last       = lst;
    return r;
  endfunction

  function automatic logic [15:0] pixel_rgb();
    logic [15:0] idx;
    logic        fore;
    idx = by_row ? row_idx : col_idx;
    case (fill_style)
      STYLE_SOLID:  fore = 1'b1;
      STYLE_DASHED: fore = ~idx[3];
      STYLE_DOTTED: fore = ~idx[0];
      default:      fore = 1'b0;
    endcase
    return fore ? fg : bg;
  endfunction

  // Advances the predicted state by one transaction; returns 1 when a byte is due.
  function automatic bit next_panel_byte(input item_t it, output result_t r);
    int unsigned w, h;
    logic [15:0] col_end, row_end, rgb;
    logic        done;
    r = '0;
    if (it.kind == KIND_DRAW) begin
      if (phase_q != PH_IDLE) return 1'b0;
      if (it.origin_x >= SCREEN_WIDTH || it.origin_y >= SCREEN_HEIGHT) return 1'b0;
      w = it.extent_x;
      h = it.extent_y;
      if (it.origin_x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - it.origin_x;
      if (it.origin_y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - it.origin_y;
      col0       = it.origin_x;
      row0       = it.origin_y;
      width      = w[15:0];
      height     = h[15:0];
      fill_style = style_e'(it.style);
      by_row     = it.pattern_axis;
      fg         = it.color;
      bg         = it.background;
      row_idx    = '0;
      col_idx    = '0;
      lo_next    = 1'b0;
      phase_q    = PH_CASET;
      return 1'b0;
    end
    // end coordinates wrap mod 2^16
    col_end = col0 + width - 16'd1;
    row_end = row0 + height - 16'd1;
    case (phase_q)
      PH_CASET: begin
        r = panel_byte(CMD_COLUMN_SET, 1'b0, 1'b1, 1'b0);
        phase_q = PH_XS_HI;
      end
      PH_XS_HI: begin
        r = panel_byte(col0[15:8], 1'b1, 1'b0, 1'b0);
        phase_q = PH_XS_LO;
      end
      PH_XS_LO: begin
        r = panel_byte(col0[7:0], 1'b1, 1'b1, 1'b0);
        phase_q = PH_XE_HI;
      end
      PH_XE_HI: begin
        r = panel_byte(col_end[15:8], 1'b1, 1'b0, 1'b0);
        phase_q = PH_XE_LO;
      end
      PH_XE_LO: begin
        r = panel_byte(col_end[7:0], 1'b1, 1'b1, 1'b0);
        phase_q = PH_RASET;
      end
      PH_RASET: begin
        r = panel_byte(CMD_ROW_SET, 1'b0, 1'b1, 1'b0);
        phase_q = PH_YS_HI;
      end
      PH_YS_HI: begin
        r = panel_byte(row0[15:8], 1'b1, 1'b0, 1'b0);
        phase_q = PH_YS_LO;
      end
      PH_YS_LO: begin
        r = panel_byte(row0[7:0], 1'b1, 1'b1, 1'b0);
        phase_q = PH_YE_HI;
      end
      PH_YE_HI: begin
        r = panel_byte(row_end[15:8], 1'b1, 1'b0, 1'b0);
        phase_q = PH_YE_LO;
      end
      PH_YE_LO: begin
        r = panel_byte(row_end[7:0], 1'b1, 1'b1, 1'b0);
        phase_q = PH_RAMWR;
      end
      PH_RAMWR: begin
        if (width == '0 || height == '0) begin
          // empty window: memory write closes the sequence
          r = panel_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b1);
          phase_q = PH_IDLE;
        end else begin
          r = panel_byte(CMD_MEMORY_WRITE, 1'b0, 1'b1, 1'b0);
          phase_q = PH_PIXELS;
          row_idx = '0;
          col_idx = '0;
          lo_next = 1'b0;
        end
      end
      PH_PIXELS: begin
        rgb = pixel_rgb();
        if (!lo_next) begin
          r = panel_byte(rgb[15:8], 1'b1, 1'b0, 1'b0);
          lo_next = 1'b1;
        end else begin
          lo_next = 1'b0;
          done    = 1'b0;
          col_idx = col_idx + 16'd1;
          if (col_idx >= width) begin
            col_idx = '0;
            row_idx = row_idx + 16'd1;
            done    = (row_idx >= height);
          end
          r = panel_byte(rgb[7:0], 1'b1, done, done);
          if (done) begin
            phase_q = PH_IDLE;
            row_idx = '0;
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      if (n_fail < MAX_REPORTS) $error("%s: expected %0h, actual %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want, pred;
    item_t   seen;
    if (!rst_ni) begin
      phase_q    = PH_IDLE;
      col0       = '0;
      row0       = '0;
      width      = '0;
      height     = '0;
      row_idx    = '0;
      col_idx    = '0;
      lo_next    = 1'b0;
      fg         = '0;
      bg         = '0;
      fill_style = STYLE_SOLID;
      by_row     = 1'b0;
      bytes_due.delete();
      pending_o <= 0;
    end else begin
      // output first: a byte never belongs to the transaction accepted this cycle
      if (out_mon.valid && out_mon.ready) begin
        got = panel_byte(out_mon.byte_out, out_mon.is_data, out_mon.cs_release, out_mon.last);
        if (bytes_due.size() == 0) begin
          if (n_fail < MAX_REPORTS)
            $error("byte_out: expected no transaction, actual %0h", got.byte_out);
          n_fail++;
        end else begin
          want = bytes_due.pop_front();
          check_field("byte_out", want.byte_out, got.byte_out);
          check_field("is_data", 8'(want.is_data), 8'(got.is_data));
          check_field("cs_release", 8'(want.cs_release), 8'(got.cs_release));
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        seen.kind         = in_mon.kind;
        seen.origin_x     = in_mon.origin_x;
        seen.origin_y     = in_mon.origin_y;
        seen.extent_x     = in_mon.extent_x;
        seen.extent_y     = in_mon.extent_y;
        seen.style        = in_mon.style;
        seen.pattern_axis = in_mon.pattern_axis;
        seen.color        = in_mon.color;
        seen.background   = in_mon.background;
        if (next_panel_byte(seen, pred)) bytes_due.push_back(pred);
      end
      pending_o <= bytes_due.size();
    end
  end

endmodule

### dv/tb_top.sv
// Top of the lcd_window_fill_stream testbench: clock, reset, bursty draw/advance
// stimulus, a stalling byte receiver, a watchdog and the verdict.
// Depends on lwf_pkg, lwf_stream_if, lcd_window_fill_stream and lwf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lwf_pkg::*;

  localparam int unsigned ITEM_TARGET    = 700;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES  = 10;

  logic        clk_i;
  logic        rst_ni;
  int unsigned bytes_pending;
  int unsigned fail_count;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned idle_cycles = 0;

  lwf_in_if  in_if ();
  lwf_out_if out_if ();

  lcd_window_fill_stream i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lwf_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .pending_o    (bytes_pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic item_t random_item(input kind_e k);
    item_t it;
    it.kind         = k;
    it.origin_x     = 16'($urandom);
    it.origin_y     = 16'($urandom);
    it.extent_x     = 16'($urandom);
    it.extent_y     = 16'($urandom);
    it.style        = 2'($urandom);
    it.pattern_axis = 1'($urandom);
    it.color        = 16'($urandom);
    it.background   = 16'($urandom);
    return it;
  endfunction

  function automatic item_t draw_cmd(input int unsigned ox, oy, w, h, input style_e st,
                                     input logic axis, input logic [15:0] fore, back);
    item_t it;
    it              = random_item(KIND_DRAW);
    it.origin_x     = 16'(ox);
    it.origin_y     = 16'(oy);
    it.extent_x     = 16'(w);
    it.extent_y     = 16'(h);
    it.style        = st;
    it.pattern_axis = axis;
    it.color        = fore;
    it.background   = back;
    return it;
  endfunction

  function automatic item_t random_fill();
    item_t d;
    d          = random_item(KIND_DRAW);
    d.origin_x = 16'($urandom_range(0, SCREEN_WIDTH - 1));
    d.origin_y = 16'($urandom_range(0, SCREEN_HEIGHT - 1));
    case ($urandom_range(0, 7))
      0: begin
        // raw 16-bit extents, origin near the lower right corner keeps it small
        d.origin_x = 16'(SCREEN_WIDTH - $urandom_range(1, 8));
        d.origin_y = 16'(SCREEN_HEIGHT - $urandom_range(1, 8));
      end
      1: begin
        d.extent_x = 16'($urandom_range(9, 24));
        d.extent_y = 16'($urandom_range(0, 3));
      end
      2: begin
        d.extent_x = 16'($urandom_range(0, 3));
        d.extent_y = 16'($urandom_range(9, 24));
      end
      default: begin
        d.extent_x = 16'($urandom_range(0, 5));
        d.extent_y = 16'($urandom_range(0, 5));
      end
    endcase
    return d;
  endfunction

  task automatic drive_fields(input item_t it);
    in_if.kind         <= it.kind;
    in_if.origin_x     <= it.origin_x;
    in_if.origin_y     <= it.origin_y;
    in_if.extent_x     <= it.extent_x;
    in_if.extent_y     <= it.extent_y;
    in_if.style        <= it.style;
    in_if.pattern_axis <= it.pattern_axis;
    in_if.color        <= it.color;
    in_if.background   <= it.background;
  endtask

  // Called right after a rising edge; returns at the edge that accepts the transaction.
  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
    end
    drive_fields(it);
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
  endtask

  task automatic wait_all_bytes();
    int unsigned n;
    n = 0;
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (bytes_pending != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  // One draw followed by exactly the advances its sequence needs.
  task automatic run_fill(input item_t d, input int unsigned noise_pct);
    int unsigned w, h, n_adv;
    send_item(d);
    if (d.origin_x >= SCREEN_WIDTH || d.origin_y >= SCREEN_HEIGHT) return;
    w = d.extent_x;
    h = d.extent_y;
    if (d.origin_x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - d.origin_x;
    if (d.origin_y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - d.origin_y;
    n_adv = 11 + 2 * w * h;
    for (int i = 0; i < n_adv; i++) begin
      // a draw while busy must be ignored
      if ($urandom_range(0, 99) < noise_pct) send_item(random_item(KIND_DRAW));
      send_item(random_item(KIND_ADVANCE));
    end
    items_sent += n_adv + 1;
  endtask

  initial begin
    int unsigned mode, span, tick;
    out_if.ready <= 1'b0;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 160);
      end
      span--;
      tick++;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom);
        2: out_if.ready <= ($urandom_range(0, 4) == 0);
        default: out_if.ready <= (tick % 5 != 0) && (tick % 7 != 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lcd_window_fill_stream test failed");
      $finish;
    end
  end

  initial begin
    item_t d;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    drive_fields('0);
    burst_left = 0;
    items_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, clipping, wrapped ends, every style, dropped draws
    send_item(random_item(KIND_ADVANCE));
    run_fill(draw_cmd(0, 0, 1, 1, STYLE_SOLID, 1'b0, 16'hFFFF, 16'h0000), 0);
    run_fill(draw_cmd(319, 239, 16'hFFFF, 16'hFFFF, STYLE_DASHED, 1'b1, 16'h0000, 16'hFFFF), 0);
    run_fill(draw_cmd(0, 0, 0, 0, STYLE_SOLID, 1'b0, 16'h1234, 16'h5678), 0);
    run_fill(draw_cmd(10, 20, 0, 5, STYLE_DOTTED, 1'b0, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(7, 3, 3, 0, STYLE_BACK, 1'b1, 16'($urandom), 16'($urandom)), 0);
    send_item(draw_cmd(320, 0, 4, 4, STYLE_SOLID, 1'b0, 16'($urandom), 16'($urandom)));
    send_item(draw_cmd(0, 240, 4, 4, STYLE_SOLID, 1'b0, 16'($urandom), 16'($urandom)));
    send_item(draw_cmd(16'hFFFF, 16'hFFFF, 1, 1, STYLE_SOLID, 1'b0, 16'hFFFF, 16'hFFFF));
    send_item(random_item(KIND_ADVANCE));
    run_fill(draw_cmd(5, 6, 20, 2, STYLE_DASHED, 1'b0, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(300, 200, 2, 18, STYLE_DASHED, 1'b1, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(1, 2, 5, 3, STYLE_DOTTED, 1'b0, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(3, 4, 3, 4, STYLE_DOTTED, 1'b1, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(9, 9, 4, 2, STYLE_BACK, 1'b0, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(300, 100, 70, 1, STYLE_SOLID, 1'b0, 16'($urandom), 16'($urandom)), 50);
    run_fill(draw_cmd(310, 0, 16'hFFFF, 1, STYLE_DOTTED, 1'b0, 16'($urandom), 16'($urandom)), 0);
    run_fill(draw_cmd(0, 230, 1, 16'hFFFF, STYLE_DASHED, 1'b1, 16'($urandom), 16'($urandom)), 0);
    wait_all_bytes();

    // random: mostly complete fills, some idle advances and off-screen draws
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: send_item(random_item(KIND_ADVANCE));
        1: begin
          d = random_item(KIND_DRAW);
          if ($urandom_range(0, 1)) d.origin_x = 16'($urandom_range(SCREEN_WIDTH, 16'hFFFF));
          else d.origin_y = 16'($urandom_range(SCREEN_HEIGHT, 16'hFFFF));
          send_item(d);
        end
        default: run_fill(random_fill(), 6);
      endcase
      if ($urandom_range(0, 15) == 0) wait_all_bytes();
    end

    wait_all_bytes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("lcd_window_fill_stream test passed");
    end else begin
      $display("lcd_window_fill_stream test failed");
    end
    $finish;
  end

endmodule

### lcd_window_fill_stream.f
hdl/lwf_pkg.sv
hdl/lwf_stream_if.sv
hdl/lwf_in_stage.sv
hdl/lwf_seq.sv
hdl/lcd_window_fill_stream.sv
hdl/lwf_checker.sv
dv/lwf_checker.sv
dv/tb_top.sv
